FILE: design/mct_pkg.sv
// mct_pkg: types and constants shared by the mutex contention tracker
// no dependencies; every other file imports this package
package mct_pkg;

	// input mode codes
	localparam logic [2:0] MODE_ATTEMPT = 3'd0;
	localparam logic [2:0] MODE_RETURN  = 3'd1;
	localparam logic [2:0] MODE_UNLOCK  = 3'd2;
	localparam logic [2:0] MODE_TRYRET  = 3'd3;
	localparam logic [2:0] MODE_QUERY   = 3'd4;

	// result kind codes
	localparam logic [2:0] KIND_CONTEND = 3'd0;
	localparam logic [2:0] KIND_LONG    = 3'd1;
	localparam logic [2:0] KIND_WSTATS  = 3'd2;
	localparam logic [2:0] KIND_HSTATS  = 3'd3;
	localparam logic [2:0] KIND_ABSENT  = 3'd4;

	// configuration register indexes
	localparam logic [7:0] REG_TARGET  = 8'd0;
	localparam logic [7:0] REG_FILTER  = 8'd1;
	localparam logic [7:0] REG_WAIT_TH = 8'd2;
	localparam logic [7:0] REG_HOLD_TH = 8'd3;

	localparam logic [63:0] RST_WAIT_NS = 64'd1000000;
	localparam logic [63:0] RST_HOLD_NS = 64'd10 * RST_WAIT_NS;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [2:0]         mode;
		logic [31:0]        process_id;
		logic [31:0]        thread_id;
		logic               pid_listed;
		logic [63:0]        lock_address;
		logic [63:0]        now_ns;
		logic signed [31:0] call_stack;
		logic               call_ok;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [31:0]        out_process;
		logic [31:0]        out_thread;
		logic [63:0]        out_lock;
		logic signed [31:0] out_stack;
		logic [63:0]        out_time;
		logic [63:0]        duration_or_sum;
		logic [63:0]        largest_ns;
		logic [63:0]        smallest_ns;
		logic [31:0]        tally;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  index;
		logic [63:0] value;
	} cfg_beat_t;

	typedef struct packed {
		logic [31:0] target_process;
		logic        filter_enable;
		logic [63:0] wait_threshold;
		logic [63:0] hold_limit;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_ATTEMPT,
		OP_RETURN,
		OP_UNLOCK,
		OP_TRYRET,
		OP_QUERY
	} op_t;

	// classified event as it travels through the queue
	typedef struct packed {
		op_t         op;
		logic [31:0] pid;
		logic [31:0] tid;
		logic [63:0] lock;
		logic [63:0] now;
		logic [31:0] stack;
		logic        ok;
	} job_t;

	typedef struct packed {
		logic [63:0] lock;
		logic [63:0] start;
		logic [31:0] stack;
	} pend_rec_t;

	typedef struct packed {
		logic [31:0] thread;
		logic [63:0] acquired;
		logic [31:0] stack;
	} own_rec_t;

	typedef struct packed {
		logic [63:0] wsum;
		logic [63:0] hsum;
		logic [63:0] wmax;
		logic [63:0] hmax;
		logic [63:0] wmin;
		logic [63:0] hmin;
		logic [31:0] count;
	} st_rec_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_FIND,
		B_RET_RD,
		B_RET_CHK,
		B_EMIT_C,
		B_UNL_RD,
		B_SFIND,
		B_SUPD,
		B_EMIT_H,
		B_OWN,
		B_QABS,
		B_Q1,
		B_Q2
	} back_state_t;

endpackage

FILE: design/mct_stream_if.sv
// mct_stream_if: valid/ready channel carrying one payload type per beat
// depends on mct_pkg for the payload types used by the instances
interface mct_stream_if import mct_pkg::*; #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/mct_ram.sv
// mct_ram: generic memory, one write port, one read port with registered data
// depends on nothing but mct_pkg import convention
module mct_ram import mct_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

FILE: design/mct_front.sv
// mct_front: configuration registers, event accept, process filter and classification
// depends on mct_pkg and mct_stream_if
module mct_front import mct_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	mct_stream_if.sink          evt,
	mct_stream_if.sink          cfg,
	input  logic                q_full,
	output logic                push,
	output job_t                job,
	output cfg_t                regs
);
	cfg_t regs_q;
	logic keep;
	logic profiled;

	assign regs = regs_q;
	assign cfg.ready = 1'b1;
	assign evt.ready = !q_full;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.target_process <= '0;
			regs_q.filter_enable  <= 1'b0;
			regs_q.wait_threshold <= RST_WAIT_NS;
			regs_q.hold_limit     <= RST_HOLD_NS;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_TARGET:  regs_q.target_process <= cfg.data.value[31:0];
				REG_FILTER:  regs_q.filter_enable  <= cfg.data.value[0];
				REG_WAIT_TH: regs_q.wait_threshold <= cfg.data.value;
				REG_HOLD_TH: regs_q.hold_limit     <= cfg.data.value;
				default: ;
			endcase
		end
	end

	// process filter
	always_comb begin
		if (evt.data.process_id == '0) begin
			profiled = 1'b0;
		end else if (evt.data.pid_listed) begin
			profiled = 1'b1;
		end else if (regs_q.target_process != '0) begin
			profiled = (evt.data.process_id == regs_q.target_process);
		end else begin
			profiled = !regs_q.filter_enable;
		end
	end

	// classify the beat; queries bypass the filter, unknown modes drop
	always_comb begin
		job.pid   = evt.data.process_id;
		job.tid   = evt.data.thread_id;
		job.lock  = evt.data.lock_address;
		job.now   = evt.data.now_ns;
		job.stack = evt.data.call_stack;
		job.ok    = evt.data.call_ok;
		job.op    = OP_QUERY;
		keep      = profiled;
		unique case (evt.data.mode)
			MODE_ATTEMPT: job.op = OP_ATTEMPT;
			MODE_RETURN:  job.op = OP_RETURN;
			MODE_UNLOCK:  job.op = OP_UNLOCK;
			MODE_TRYRET:  job.op = OP_TRYRET;
			MODE_QUERY: begin
				job.op = OP_QUERY;
				keep   = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign push = evt.valid && !q_full && keep;
endmodule

FILE: design/mct_queue.sv
// mct_queue: short queue of classified events between front and back
// depends on mct_pkg
module mct_queue import mct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic empty,
	output job_t head
);
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// payload storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end
endmodule

FILE: design/mct_back.sv
// mct_back: pending, owner and statistics tables, sequencer and result register
// depends on mct_pkg, mct_stream_if and mct_ram
module mct_back import mct_pkg::*; #(
	parameter int PENDING_DEPTH = 64,
	parameter int OWNER_DEPTH = 64,
	parameter int STATS_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        regs,
	input  logic        q_empty,
	input  job_t        head,
	output logic        pop,
	mct_stream_if.source res
);
	localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int OIW = (OWNER_DEPTH > 1) ? $clog2(OWNER_DEPTH) : 1;
	localparam int SIW = (STATS_DEPTH > 1) ? $clog2(STATS_DEPTH) : 1;

	back_state_t state_q, state_d;

	// working registers of the current event
	job_t           job_q;
	logic [PIW-1:0] pidx_q;
	logic [OIW-1:0] oidx_q;
	logic [SIW-1:0] sidx_q;
	logic           st_hit_q;
	logic           sok_q;
	logic [63:0]    own_lock_q;
	logic [31:0]    own_stack_q;
	logic [63:0]    sk_lock_q;
	logic [31:0]    sk_stack_q;
	logic [63:0]    dur_q;

	// table keys and valid bits
	logic [PENDING_DEPTH-1:0] pend_valid_q;
	logic [63:0]              pend_key_q [PENDING_DEPTH];
	logic [OWNER_DEPTH-1:0]   own_valid_q;
	logic [63:0]              own_key_q [OWNER_DEPTH];
	logic [STATS_DEPTH-1:0]   st_valid_q;
	logic [63:0]              st_lock_q [STATS_DEPTH];
	logic [31:0]              st_stack_q [STATS_DEPTH];

	// lookup results
	logic           ph, pf, oh, of, sh, sf;
	logic [PIW-1:0] ph_idx, pf_idx;
	logic [OIW-1:0] oh_idx, of_idx;
	logic [SIW-1:0] sh_idx, sf_idx;
	logic [63:0]    tkey;

	// memory ports
	logic           pend_we, own_we, st_we;
	logic [PIW-1:0] pend_waddr, pend_raddr;
	logic [OIW-1:0] own_waddr, own_raddr;
	logic [SIW-1:0] st_waddr, st_raddr;
	pend_rec_t      pend_wdata, pend_rdata;
	own_rec_t       own_wdata, own_rdata;
	st_rec_t        st_wdata, st_rdata;

	// table bookkeeping
	logic           pend_clr, own_clr, st_new;
	logic [PIW-1:0] pend_caddr;

	// result register
	logic      out_valid_q;
	out_item_t out_q;
	logic      out_load;
	out_item_t out_d;
	logic      slot_free;

	assign tkey = {job_q.pid, job_q.tid};
	assign slot_free = !out_valid_q || res.ready;
	assign res.valid = out_valid_q;
	assign res.data = out_q;

	// pending lookup by thread key, lowest index wins
	always_comb begin
		ph = 1'b0; pf = 1'b0; ph_idx = '0; pf_idx = '0;
		for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
			if (pend_valid_q[i] && pend_key_q[i] == tkey) begin
				ph = 1'b1;
				ph_idx = PIW'(i);
			end
			if (!pend_valid_q[i]) begin
				pf = 1'b1;
				pf_idx = PIW'(i);
			end
		end
	end

	// owner lookup by lock address
	always_comb begin
		oh = 1'b0; of = 1'b0; oh_idx = '0; of_idx = '0;
		for (int i = OWNER_DEPTH - 1; i >= 0; i--) begin
			if (own_valid_q[i] && own_key_q[i] == own_lock_q) begin
				oh = 1'b1;
				oh_idx = OIW'(i);
			end
			if (!own_valid_q[i]) begin
				of = 1'b1;
				of_idx = OIW'(i);
			end
		end
	end

	// statistics lookup by lock and stack
	always_comb begin
		sh = 1'b0; sf = 1'b0; sh_idx = '0; sf_idx = '0;
		for (int i = STATS_DEPTH - 1; i >= 0; i--) begin
			if (st_valid_q[i] && st_lock_q[i] == sk_lock_q && st_stack_q[i] == sk_stack_q) begin
				sh = 1'b1;
				sh_idx = SIW'(i);
			end
			if (!st_valid_q[i]) begin
				sf = 1'b1;
				sf_idx = SIW'(i);
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		pend_we    = 1'b0;
		pend_clr   = 1'b0;
		pend_caddr = pidx_q;
		pend_waddr = ph ? ph_idx : pf_idx;
		pend_wdata = '{lock: job_q.lock, start: job_q.now, stack: job_q.stack};
		pend_raddr = (state_q == B_FIND) ? ph_idx : pidx_q;
		own_we     = 1'b0;
		own_clr    = 1'b0;
		own_waddr  = oh ? oh_idx : of_idx;
		own_wdata  = '{thread: job_q.tid, acquired: job_q.now, stack: own_stack_q};
		own_raddr  = (state_q == B_FIND) ? oh_idx : oidx_q;
		st_we      = 1'b0;
		st_new     = 1'b0;
		st_waddr   = sidx_q;
		st_wdata   = st_rdata;
		st_raddr   = (state_q == B_SFIND) ? sh_idx : sidx_q;
		out_load   = 1'b0;
		out_d      = '0;
		out_d.out_lock  = sk_lock_q;
		out_d.out_stack = sk_stack_q;
		out_d.tally     = st_rdata.count;

		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					unique case (head.op)
						OP_ATTEMPT, OP_RETURN, OP_UNLOCK: state_d = B_FIND;
						OP_TRYRET: state_d = head.ok ? B_OWN : B_IDLE;
						OP_QUERY: state_d = B_SFIND;
						default: state_d = B_IDLE;
					endcase
				end
			end
			B_FIND: begin
				state_d = B_IDLE;
				unique case (job_q.op)
					OP_ATTEMPT: pend_we = ph || pf;
					OP_RETURN: begin
						if (ph && !job_q.ok) begin
							// failed return drops the entry found this cycle
							pend_clr   = 1'b1;
							pend_caddr = ph_idx;
						end else if (ph) begin
							state_d = B_RET_RD;
						end
					end
					OP_UNLOCK: begin
						if (oh) begin
							state_d = B_UNL_RD;
						end
					end
					default: state_d = B_IDLE;
				endcase
			end
			B_RET_RD: state_d = B_RET_CHK;
			B_RET_CHK: state_d = (dur_q > regs.wait_threshold) ? B_EMIT_C : B_OWN;
			B_EMIT_C: begin
				out_d.kind        = KIND_CONTEND;
				out_d.out_process = job_q.pid;
				out_d.out_thread  = job_q.tid;
				out_d.out_time    = job_q.now;
				out_d.duration_or_sum = dur_q;
				out_d.tally       = '0;
				out_d.last        = 1'b1;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = B_SFIND;
				end
			end
			B_UNL_RD: state_d = (own_rdata.thread == job_q.tid) ? B_SFIND : B_IDLE;
			B_SFIND: begin
				if (job_q.op == OP_QUERY) begin
					state_d = sh ? B_Q1 : B_QABS;
				end else begin
					state_d = B_SUPD;
				end
			end
			B_SUPD: begin
				if (job_q.op == OP_RETURN) begin
					state_d = B_OWN;
					if (st_hit_q) begin
						st_we = 1'b1;
						st_wdata.wsum  = st_rdata.wsum + dur_q;
						st_wdata.count = (st_rdata.count != '1) ? st_rdata.count + 1'b1
							: st_rdata.count;
						st_wdata.wmax  = (dur_q > st_rdata.wmax) ? dur_q : st_rdata.wmax;
						st_wdata.wmin  = (st_rdata.wmin == '0 || dur_q < st_rdata.wmin) ? dur_q
							: st_rdata.wmin;
					end else if (sok_q) begin
						st_we  = 1'b1;
						st_new = 1'b1;
						st_wdata = '{wsum: dur_q, hsum: '0, wmax: dur_q, hmax: '0,
							wmin: dur_q, hmin: '0, count: 32'd1};
					end
				end else begin
					if (st_hit_q) begin
						st_we = 1'b1;
						st_wdata.hsum = st_rdata.hsum + dur_q;
						st_wdata.hmax = (dur_q > st_rdata.hmax) ? dur_q : st_rdata.hmax;
						st_wdata.hmin = (st_rdata.hmin == '0 || dur_q < st_rdata.hmin) ? dur_q
							: st_rdata.hmin;
					end
					if (dur_q > regs.hold_limit) begin
						state_d = B_EMIT_H;
					end else begin
						own_clr = 1'b1;
						state_d = B_IDLE;
					end
				end
			end
			B_EMIT_H: begin
				out_d.kind        = KIND_LONG;
				out_d.out_process = job_q.pid;
				out_d.out_thread  = job_q.tid;
				out_d.out_time    = job_q.now;
				out_d.duration_or_sum = dur_q;
				out_d.tally       = '0;
				out_d.last        = 1'b1;
				if (slot_free) begin
					out_load = 1'b1;
					own_clr  = 1'b1;
					state_d  = B_IDLE;
				end
			end
			B_OWN: begin
				own_we   = oh || of;
				pend_clr = (job_q.op == OP_RETURN);
				state_d  = B_IDLE;
			end
			B_QABS: begin
				out_d.kind  = KIND_ABSENT;
				out_d.tally = '0;
				out_d.last  = 1'b1;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			B_Q1: begin
				out_d.kind = KIND_WSTATS;
				out_d.duration_or_sum = st_rdata.wsum;
				out_d.largest_ns  = st_rdata.wmax;
				out_d.smallest_ns = st_rdata.wmin;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = B_Q2;
				end
			end
			B_Q2: begin
				out_d.kind = KIND_HSTATS;
				out_d.duration_or_sum = st_rdata.hsum;
				out_d.largest_ns  = st_rdata.hmax;
				out_d.smallest_ns = st_rdata.hmin;
				out_d.last = 1'b1;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				job_q       <= head;
				own_lock_q  <= head.lock;
				own_stack_q <= head.stack;
				sk_lock_q   <= head.lock;
				sk_stack_q  <= head.stack;
			end
			B_FIND: begin
				pidx_q <= ph_idx;
				oidx_q <= oh_idx;
			end
			B_RET_RD: begin
				dur_q       <= job_q.now - pend_rdata.start;
				own_lock_q  <= pend_rdata.lock;
				own_stack_q <= pend_rdata.stack;
				sk_lock_q   <= pend_rdata.lock;
				sk_stack_q  <= pend_rdata.stack;
			end
			B_UNL_RD: begin
				dur_q      <= job_q.now - own_rdata.acquired;
				sk_stack_q <= own_rdata.stack;
			end
			B_SFIND: begin
				st_hit_q <= sh;
				sok_q    <= sh || sf;
				sidx_q   <= sh ? sh_idx : sf_idx;
			end
			default: ;
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= '0;
			own_valid_q  <= '0;
			st_valid_q   <= '0;
		end else begin
			if (pend_we) begin
				pend_valid_q[pend_waddr] <= 1'b1;
			end
			if (pend_clr) begin
				pend_valid_q[pend_caddr] <= 1'b0;
			end
			if (own_we) begin
				own_valid_q[own_waddr] <= 1'b1;
			end
			if (own_clr) begin
				own_valid_q[oidx_q] <= 1'b0;
			end
			if (st_new) begin
				st_valid_q[sidx_q] <= 1'b1;
			end
		end
	end

	// lookup keys
	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_key_q[pend_waddr] <= tkey;
		end
		if (own_we) begin
			own_key_q[own_waddr] <= own_lock_q;
		end
		if (st_new) begin
			st_lock_q[sidx_q]  <= sk_lock_q;
			st_stack_q[sidx_q] <= sk_stack_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	mct_ram #(.WIDTH($bits(pend_rec_t)), .DEPTH(PENDING_DEPTH)) u_pend_ram (
		.clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
		.raddr(pend_raddr), .rdata(pend_rdata)
	);

	mct_ram #(.WIDTH($bits(own_rec_t)), .DEPTH(OWNER_DEPTH)) u_own_ram (
		.clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
		.raddr(own_raddr), .rdata(own_rdata)
	);

	mct_ram #(.WIDTH($bits(st_rec_t)), .DEPTH(STATS_DEPTH)) u_st_ram (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);
endmodule

FILE: design/mutex_contention_tracker.sv
// mutex_contention_tracker: top level, front classifier, event queue and table back end
// depends on mct_pkg, mct_stream_if, mct_front, mct_queue, mct_back
//
// channel  dir  payload      beat taken when
// evt      in   in_item_t    evt.valid && evt.ready
// res      out  out_item_t   res.valid && res.ready
// cfg      in   cfg_beat_t   cfg.valid (ready held high)
//
// the front takes one event per cycle, unless full, into a two-entry queue; the back drains it
// attempts, failed or unmatched lock returns, trylock returns, lock returns with or without
// contention, unlocks and queries each pass through the steps they need among the sequential
// lookup, memory read and write-back of the tables; the back end pops no new event until done
// reset clears all valid bits at once; no clearing pass is needed
// a stalled result holds the back end; the queue keeps accepting until full
module mutex_contention_tracker import mct_pkg::*; #(
	parameter int PENDING_DEPTH = 64,
	parameter int OWNER_DEPTH = 64,
	parameter int STATS_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	mct_stream_if.sink    evt,
	mct_stream_if.source  res,
	mct_stream_if.sink    cfg
);
	logic q_full, q_empty, push, pop;
	job_t push_job, head;
	cfg_t regs;

	mct_front u_front (
		.clk(clk), .arst_n(arst_n), .evt(evt), .cfg(cfg),
		.q_full(q_full), .push(push), .job(push_job), .regs(regs)
	);

	mct_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job),
		.pop(pop), .full(q_full), .empty(q_empty), .head(head)
	);

	mct_back #(
		.PENDING_DEPTH(PENDING_DEPTH),
		.OWNER_DEPTH(OWNER_DEPTH),
		.STATS_DEPTH(STATS_DEPTH)
	) u_back (
		.clk(clk), .arst_n(arst_n), .regs(regs), .q_empty(q_empty),
		.head(head), .pop(pop), .res(res)
	);
endmodule
